[src/maad_pkg.sv]
// Shared types and constants for the moving-average anomaly detector.
`default_nettype none

package maad_pkg;

  // Largest window the ring can hold
  localparam int WINDOW_MAX_DEF = 64;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int WLEN_W    = 7;
  localparam int THRESH_W  = 24;
  localparam int MAXREP_W  = 16;
  localparam int INDEX_W   = 24;
  localparam int QUO_W     = 24;   // mean in Q.8 always fits 24 bits
  localparam int DIFF_W    = 25;
  localparam int FRAC_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Divider sequencing: one quotient bit per step
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REPORTS = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DIFF,
    ST_DECIDE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the beat, start the mean division
    logic div_step;  // one restoring-divider step
    logic diff_load; // register signed mean and difference
    logic commit;    // update series state, emit a report if flagged
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;      // window filled before this sample
    logic report;    // sample qualifies as a report
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

[src/maad_ctrl.sv]
// Sequencer for the anomaly detector: capture, divide, difference, decide.
`default_nettype none

module maad_ctrl
  import maad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = status.full ? ST_DIVIDE : ST_DECIDE;
        end
      end
      ST_DIVIDE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.report || status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = accept;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_DIFF: begin
        cmd.diff_load = 1'b1;
      end
      ST_DECIDE: begin
        cmd.commit = !status.report || status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/maad_dpath.sv]
// Datapath: sample ring, running sum, mean divider, deviation and report register.
`default_nettype none

module maad_dpath
  import maad_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dp_cmd_t                     cmd,
  output dp_status_t                       status,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample,
  input  wire logic                        in_last_sample,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DAT_W-1:0]        cfg_wdata,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [INDEX_W-1:0]               out_sample_index,
  output logic signed [SAMPLE_W-1:0]       out_sample_value,
  output logic signed [QUO_W-1:0]          out_expected,
  output logic [QUO_W-1:0]                 out_deviation
);

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int DVD_W = SUM_W + FRAC_W;

  // Configuration
  logic [WLEN_W-1:0]   wlen_r;
  logic [THRESH_W-1:0] thresh_r;
  logic [MAXREP_W-1:0] maxrep_r;
  logic                wlen_wr;

  // Series state
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic [WIN_W-1:0]        fill_r, fill_nxt;
  logic [INDEX_W-1:0]      pos_r, pos_nxt;
  logic [MAXREP_W-1:0]     reps_r, reps_nxt;

  // Per-item working registers
  logic signed [SAMPLE_W-1:0] samp_r;
  logic                       last_r;
  logic                       full_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic                       neg_r;
  logic [WIN_W-1:0]           rem_r;
  logic [QUO_W-1:0]           quo_r;
  logic signed [QUO_W-1:0]    mean_r;
  logic signed [DIFF_W-1:0]   diff_r;

  // Ring memory
  logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];

  // Output register
  logic                       out_valid_r;
  logic [INDEX_W-1:0]         o_idx_r;
  logic signed [SAMPLE_W-1:0] o_val_r;
  logic signed [QUO_W-1:0]    o_exp_r;
  logic [QUO_W-1:0]           o_dev_r;

  logic [WIN_W-1:0]           win;
  logic [SUM_W-1:0]           sum_mag;
  logic [DVD_W-1:0]           dividend;
  logic [WIN_W:0]             trial;
  logic                       trial_ok;
  logic signed [QUO_W-1:0]    mean_val;
  logic signed [DIFF_W-1:0]   diff_val;
  logic [DIFF_W-1:0]          dev_full;
  logic [QUO_W-1:0]           dev;
  logic                       report;

  assign wlen_wr = cfg_we && (cfg_index == REG_WINDOW_LEN);

  // Clamp window length into 1..WINDOW_MAX
  always_comb begin
    if (wlen_r == '0) begin
      win = WIN_W'(1);
    end else if (int'(wlen_r) > WINDOW_MAX) begin
      win = WIN_W'(WINDOW_MAX);
    end else begin
      win = WIN_W'(wlen_r);
    end
  end

  // Magnitude of the sum, scaled to Q.8, as divider input
  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dividend = {sum_mag, {FRAC_W{1'b0}}};

  // Restoring divider step
  assign trial    = {rem_r, quo_r[QUO_W-1]} - {1'b0, win};
  assign trial_ok = ({rem_r, quo_r[QUO_W-1]} >= {1'b0, win});

  // Signed mean and difference
  assign mean_val = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign diff_val = DIFF_W'($signed({samp_r, {FRAC_W{1'b0}}}))
                    - DIFF_W'(mean_val);

  // Absolute deviation and report decision
  assign dev_full = diff_r[DIFF_W-1] ? DIFF_W'(-diff_r) : DIFF_W'(diff_r);
  assign dev      = dev_full[QUO_W-1:0];
  assign report   = full_r && (reps_r < maxrep_r) && (dev > thresh_r);

  assign status.full     = (fill_r >= win);
  assign status.report   = report;
  assign status.out_free = !out_valid_r || out_ready;

  // Series state update at commit; cleared by a window-length write
  always_comb begin
    sum_nxt  = sum_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    reps_nxt = reps_r;
    if (wlen_wr) begin
      sum_nxt  = '0;
      wp_nxt   = '0;
      fill_nxt = '0;
      pos_nxt  = '0;
      reps_nxt = '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        sum_nxt  = '0;
        wp_nxt   = '0;
        fill_nxt = '0;
        pos_nxt  = '0;
        reps_nxt = '0;
      end else begin
        sum_nxt = sum_r + SUM_W'(samp_r) - (full_r ? SUM_W'(old_r) : SUM_W'(0));
        if (!full_r) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (WIN_W'(wp_r) + 1'b1 == win) begin
          wp_nxt = '0;
        end else begin
          wp_nxt = wp_r + 1'b1;
        end
        if (pos_r != '1) begin
          pos_nxt = pos_r + 1'b1;
        end
        if (report) begin
          reps_nxt = reps_r + 1'b1;
        end
      end
    end
  end

  // Control state: configuration, series state, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= WLEN_W'(8);
      thresh_r    <= THRESH_W'(768);
      maxrep_r    <= '1;
      sum_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      reps_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN:  wlen_r   <= cfg_wdata[WLEN_W-1:0];
          REG_THRESHOLD:   thresh_r <= cfg_wdata[THRESH_W-1:0];
          REG_MAX_REPORTS: maxrep_r <= cfg_wdata[MAXREP_W-1:0];
          default: begin
            wlen_r <= wlen_r;
          end
        endcase
      end
      sum_r  <= sum_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      reps_r <= reps_nxt;
      if (cmd.commit && report) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item working registers and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r <= in_sample;
      last_r <= in_last_sample;
      full_r <= status.full;
      neg_r  <= sum_r[SUM_W-1];
      rem_r  <= WIN_W'(dividend >> QUO_W);
      quo_r  <= QUO_W'(dividend);
    end else if (cmd.div_step) begin
      rem_r <= trial_ok ? trial[WIN_W-1:0] : rem_r[WIN_W-1:0] << 1 | WIN_W'(quo_r[QUO_W-1]);
      quo_r <= {quo_r[QUO_W-2:0], trial_ok};
    end
    if (cmd.diff_load) begin
      mean_r <= mean_val;
      diff_r <= diff_val;
    end
  end

  // Ring: read the oldest entry at capture, write the new sample at commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_r <= ring_mem[wp_r];
    end
    if (cmd.commit) begin
      ring_mem[wp_r] <= samp_r;
    end
  end

  // Report payload
  always_ff @(posedge clk) begin
    if (cmd.commit && report) begin
      o_idx_r <= pos_r;
      o_val_r <= samp_r;
      o_exp_r <= mean_r;
      o_dev_r <= dev;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_index = o_idx_r;
  assign out_sample_value = o_val_r;
  assign out_expected     = o_exp_r;
  assign out_deviation    = o_dev_r;

endmodule

`default_nettype wire

[src/moving_average_anomaly_detector_core.sv]
// Top level of the moving-average anomaly detector.
//
//   Channel | Ports                                                 | Beat when
//   --------+-------------------------------------------------------+--------------------
//   input   | in_sample, in_last_sample                             | in_valid & in_ready
//   result  | out_sample_index, out_sample_value, out_expected,     | out_valid & out_ready
//           | out_deviation                                         |
//   config  | cfg_index, cfg_wdata                                  | cfg_we
//
// A sample with a full window passes through capture, 24 restoring-divider
// steps for the mean (one quotient bit each), difference and decision.
// While the window fills a sample passes through capture and decision only.
// The decision stalls only while a report is due and the result register
// still holds an untaken beat; a new sample is taken while a result waits.
// Reset clears the series state and loads default register values; the ring
// needs no clearing since only entries written in this series are read.
`default_nettype none

module moving_average_anomaly_detector_core
  import maad_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample,
  input  wire logic                        in_last_sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [INDEX_W-1:0]               out_sample_index,
  output logic signed [SAMPLE_W-1:0]       out_sample_value,
  output logic signed [QUO_W-1:0]          out_expected,
  output logic [QUO_W-1:0]                 out_deviation,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DAT_W-1:0]        cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  maad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  maad_dpath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_index (out_sample_index),
    .out_sample_value (out_sample_value),
    .out_expected     (out_expected),
    .out_deviation    (out_deviation)
  );

endmodule

`default_nettype wire
